// ----- rtl/i2p_pkg.sv -----
// shared types, character codes and classification functions for the infix to postfix converter
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  // one result item without its framing bits
  typedef struct packed {
    logic [7:0] sym;
    logic       valid;
    logic [1:0] err;
  } res_t;

  // command from the sequencer to the result emitter
  typedef struct packed {
    logic add;
    logic close;
    logic done;
    res_t res;
  } emit_cmd_t;

  typedef struct packed {
    logic ready;
    logic pend_v;
  } emit_stat_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] data;
  } stk_cmd_t;

  function automatic logic is_alnum(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
           (ch >= 8'h30 && ch <= 8'h39);
  endfunction

  // precedence level, shifted up by one so that "anything else" is zero
  function automatic logic [1:0] prec(input logic [7:0] ch);
    logic [1:0] p;
    p = 2'd0;
    if (ch == CH_CARET) p = 2'd3;
    else if (ch == CH_STAR || ch == CH_SLASH) p = 2'd2;
    else if (ch == CH_PLUS || ch == CH_MINUS) p = 2'd1;
    return p;
  endfunction

endpackage

// ----- rtl/i2p_stack.sv -----
// bounded operator stack with push, pop and clear
module i2p_stack (
  input  logic                   clk,
  input  logic                   rst,
  input  i2p_pkg::stk_cmd_t      cmd,
  output logic [7:0]             top,
  output logic [i2p_pkg::CNT_W-1:0] count,
  output logic                   empty,
  output logic                   full
);
  import i2p_pkg::*;

  logic [7:0]       mem [STACK_DEPTH];
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;

  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);
  assign empty  = (count == '0);
  assign full   = (count == CNT_W'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop) begin
      count <= cnt_m1;
    end
  end

  // entry storage; top is a registered copy of the entry below count
  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[count[IDX_W-1:0]] <= cmd.data;
      top                   <= cmd.data;
    end else if (cmd.pop && !cmd.clear) begin
      top <= mem[cnt_m2[IDX_W-1:0]];
    end
  end

endmodule

// ----- rtl/i2p_emit.sv -----
// result emitter: one pending result plus the output register
module i2p_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  i2p_pkg::emit_cmd_t   cmd,
  output i2p_pkg::emit_stat_t  stat,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // out_symbol
  output logic                 m_tlast,   // run_last
  output logic [3:0]           m_tuser    // symbol_valid, expression_done, error_code[1:0]
);
  import i2p_pkg::*;

  logic pend_v;
  res_t pend;
  res_t out_res;
  logic out_done;
  logic out_free;
  logic move;

  // the pending result only leaves once it is known whether it is the last one
  assign out_free    = !m_tvalid || m_tready;
  assign move        = pend_v && (cmd.add || cmd.close);
  assign stat.ready  = !pend_v || out_free;
  assign stat.pend_v = pend_v;

  assign m_tdata = out_res.sym;
  assign m_tuser = {out_res.err, out_done, out_res.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      pend_v   <= 1'b0;
    end else begin
      if (move) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.add) pend_v <= 1'b1;
      else if (cmd.close) pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res  <= pend;
      m_tlast  <= cmd.close;
      out_done <= cmd.close && cmd.done;
    end
    if (cmd.add) pend <= cmd.res;
  end

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// top level of the shunting-yard infix to postfix converter
//
//  channel   dir  tdata              tlast      tuser
//  s_*       in   symbol[7:0]        is_final   -
//  m_*       out  out_symbol[7:0]    run_last   symbol_valid, expression_done, error_code
//
// an item is taken only in the idle state; it then runs scan, end and close steps
// letters, digits and pushes pass each step once; pops repeat the scan or end step
// (single stack read port and precedence compare: one pop per cycle if output free)
// results trail by one pending slot so run_last is known when a result is released
// a stalled output holds the sequencer only on cycles that produce a result
// rst is synchronous and empties the stack, the pending slot and the output register
module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // symbol
  input  logic       s_tlast,   // is_final
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_symbol
  output logic       m_tlast,   // run_last
  output logic [3:0] m_tuser    // symbol_valid, expression_done, error_code[1:0]
);
  import i2p_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_CLOSE = 2'd3;

  logic [1:0]       state, state_next;
  logic [7:0]       sym;
  logic             fin;
  logic             any_emit;
  stk_cmd_t         stk;
  emit_cmd_t        ecmd;
  emit_stat_t       estat;
  logic [7:0]       top;
  logic [CNT_W-1:0] count;
  logic             empty, full;
  logic             pop_it;
  logic [1:0]       p_in, p_top;

  i2p_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (stk),
    .top   (top),
    .count (count),
    .empty (empty),
    .full  (full)
  );

  i2p_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ecmd),
    .stat     (estat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  assign s_tready = (state == ST_IDLE);

  // precedence compare: '^' is right-associative, everything else pops on equal
  assign p_in   = prec(sym);
  assign p_top  = prec(top);
  assign pop_it = (sym == CH_CARET) ? (p_in < p_top) : (p_in <= p_top);

  always_comb begin
    state_next = state;
    stk        = '0;
    stk.data   = sym;
    ecmd       = '0;
    ecmd.done  = fin;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (is_alnum(sym)) begin
          if (estat.ready) begin
            ecmd.add   = 1'b1;
            ecmd.res   = '{sym: sym, valid: 1'b1, err: ERR_NONE};
            state_next = ST_END;
          end
        end else if (sym == CH_RPAREN) begin
          if (empty) begin
            // unmatched close parenthesis
            if (estat.ready) begin
              stk.clear  = 1'b1;
              ecmd.add   = 1'b1;
              ecmd.res   = '{sym: 8'd0, valid: 1'b0, err: ERR_UNMATCHED};
              state_next = ST_END;
            end
          end else if (top == CH_LPAREN) begin
            stk.pop    = 1'b1;
            state_next = ST_END;
          end else if (estat.ready) begin
            stk.pop  = 1'b1;
            ecmd.add = 1'b1;
            ecmd.res = '{sym: top, valid: 1'b1, err: ERR_NONE};
          end
        end else if (sym != CH_LPAREN && !empty && pop_it) begin
          if (estat.ready) begin
            stk.pop  = 1'b1;
            ecmd.add = 1'b1;
            ecmd.res = '{sym: top, valid: 1'b1, err: ERR_NONE};
          end
        end else if (full) begin
          // overflow: drop the character and empty the stack
          if (estat.ready) begin
            stk.clear  = 1'b1;
            ecmd.add   = 1'b1;
            ecmd.res   = '{sym: 8'd0, valid: 1'b0, err: ERR_OVERFLOW};
            state_next = ST_END;
          end
        end else begin
          stk.push   = 1'b1;
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (fin && !empty) begin
          // flush, top first
          if (estat.ready) begin
            stk.pop  = 1'b1;
            ecmd.add = 1'b1;
            ecmd.res = '{sym: top, valid: 1'b1, err: ERR_NONE};
          end
        end else if (fin && !any_emit) begin
          if (estat.ready) begin
            ecmd.add   = 1'b1;
            ecmd.res   = '{sym: 8'd0, valid: 1'b0, err: ERR_NONE};
            state_next = ST_CLOSE;
          end
        end else begin
          state_next = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (estat.ready) begin
          ecmd.close = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      any_emit <= 1'b0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) any_emit <= 1'b0;
      else if (ecmd.add) any_emit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sym <= s_tdata;
      fin <= s_tlast;
    end
  end

  // every item's results are released before the next item is taken
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !estat.pend_v)
    else $error("pending result left over in idle");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SCAN)
    else $error("accepted item not scanned");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    ecmd.close && estat.pend_v |=> m_tvalid && m_tlast)
    else $error("closing result not marked last");

endmodule
